FILE: src/lfjc_pkg.sv
// ----------------------------------------------------------------------------
// lfjc_pkg
// Shared types and constants of the line-follow junction counter: beat
// layouts, configuration set, phase and motor command codes.
// ----------------------------------------------------------------------------
package lfjc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_BOOST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 3'd5;

  localparam logic [7:0]  RST_SPEED_FLOOR   = 8'd35;
  localparam logic [7:0]  RST_SPEED_STEP    = 8'd5;
  localparam logic [7:0]  RST_STEER_BOOST   = 8'd10;
  localparam logic [9:0]  RST_DEBOUNCE      = 10'd200;
  localparam logic [10:0] RST_CENTER_MAX    = 11'd800;
  localparam logic [10:0] RST_CENTER_OFFSET = 11'd110;

  localparam logic [9:0] SINCE_MAX = 10'd1023;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FOLLOW = 2'd1;
  localparam logic [1:0] PH_CREEP  = 2'd2;
  localparam logic [1:0] PH_NUDGE  = 2'd3;

  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_ADV   = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_LEFT  = 2'd3;

  // Sensor patterns as {left, middle, right}.
  localparam logic [2:0] PAT_NONE = 3'b000;
  localparam logic [2:0] PAT_R    = 3'b001;
  localparam logic [2:0] PAT_M    = 3'b010;
  localparam logic [2:0] PAT_MR   = 3'b011;
  localparam logic [2:0] PAT_L    = 3'b100;
  localparam logic [2:0] PAT_LM   = 3'b110;
  localparam logic [2:0] PAT_ALL  = 3'b111;

  typedef struct packed {
    logic       op;
    logic [3:0] target_blocks;
    logic [7:0] start_speed;
    logic       center_by_sensor;
    logic       left_on_line;
    logic       mid_on_line;
    logic       right_on_line;
    logic       stop_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_cmd;
    logic [7:0] motor_speed;
    logic [3:0] junctions_crossed;
    logic       busy_res;
    logic       finished;
    logic       aborted;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  speed_floor;
    logic [7:0]  speed_step;
    logic [7:0]  steer_boost;
    logic [9:0]  debounce_ms;
    logic [10:0] creep_limit;
    logic [10:0] nudge_len;
  } cfg_t;

endpackage

FILE: src/lfjc_if.sv
// ----------------------------------------------------------------------------
// lfjc_in_if / lfjc_out_if
// Valid/ready channels that carry one sample or start beat in and one
// result beat out.
// ----------------------------------------------------------------------------
interface lfjc_in_if;
  import lfjc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfjc_out_if;
  import lfjc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lfjc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfjc_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module lfjc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lfjc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfjc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lfjc_pkg::cfg_t                   cfg
);
  import lfjc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_floor <= RST_SPEED_FLOOR;
      cfg_r.speed_step  <= RST_SPEED_STEP;
      cfg_r.steer_boost <= RST_STEER_BOOST;
      cfg_r.debounce_ms <= RST_DEBOUNCE;
      cfg_r.creep_limit <= RST_CENTER_MAX;
      cfg_r.nudge_len   <= RST_CENTER_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_FLOOR:   cfg_r.speed_floor <= cfg_data[7:0];
        CFG_SPEED_STEP:    cfg_r.speed_step  <= cfg_data[7:0];
        CFG_STEER_BOOST:   cfg_r.steer_boost <= cfg_data[7:0];
        CFG_DEBOUNCE:      cfg_r.debounce_ms <= cfg_data[9:0];
        CFG_CENTER_MAX:    cfg_r.creep_limit <= cfg_data;
        CFG_CENTER_OFFSET: cfg_r.nudge_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/lfjc_core.sv
// ----------------------------------------------------------------------------
// lfjc_core
// Move state and the per-beat decision: steering, junction counting with
// debounce, speed ramp-down and the finish phases.
// ----------------------------------------------------------------------------
module lfjc_core #(
  parameter int COUNT_BITS = 4,
  parameter int TIMER_BITS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  lfjc_pkg::in_item_t  item,
  input  lfjc_pkg::cfg_t      cfg,
  output lfjc_pkg::out_item_t result
);
  import lfjc_pkg::*;

  localparam int PW    = COUNT_BITS + 9;
  localparam int CMP_W = (TIMER_BITS > 11) ? TIMER_BITS : 11;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [1:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] junction_count_r, junction_count_nxt;
  logic [COUNT_BITS-1:0] target_count_r, target_count_nxt;
  logic [7:0]            base_speed_r, base_speed_nxt;
  logic                  sensor_finish_r, sensor_finish_nxt;
  logic                  on_junction_r, on_junction_nxt;
  logic [9:0]            since_junction_r, since_junction_nxt;
  logic [TIMER_BITS-1:0] phase_timer_r, phase_timer_nxt;
  logic [1:0]            last_cmd_r, last_cmd_nxt;
  logic [7:0]            last_speed_r, last_speed_nxt;

  logic [2:0]            pat;
  logic [COUNT_BITS+7:0] ramp;
  logic [7:0]            cur_speed;
  logic [8:0]            boost_sum;
  logic [7:0]            boosted;
  logic [9:0]            since_inc;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]      timer_ext;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] start_target;
  logic                  finish_sensor;
  logic                  do_finish;
  logic                  do_end;
  logic                  end_abort;
  logic                  do_drive;
  logic [1:0]            drv_cmd;
  logic [7:0]            drv_speed;
  logic [1:0]            res_cmd;
  logic [7:0]            res_speed;

  assign pat          = {item.left_on_line, item.mid_on_line, item.right_on_line};
  assign ramp         = junction_count_r * cfg.speed_step;
  assign cur_speed    = (PW'(base_speed_r) < PW'(ramp) + PW'(cfg.speed_floor))
                        ? cfg.speed_floor : 8'(PW'(base_speed_r) - PW'(ramp));
  assign boost_sum    = {1'b0, cur_speed} + {1'b0, cfg.steer_boost};
  assign boosted      = boost_sum[8] ? 8'hFF : boost_sum[7:0];
  assign since_inc    = (since_junction_r < SINCE_MAX) ? since_junction_r + 10'd1
                                                       : since_junction_r;
  assign timer_inc    = (phase_timer_r < TIMER_MAX) ? phase_timer_r + 1'b1 : phase_timer_r;
  assign timer_ext    = CMP_W'(timer_inc);
  assign count_inc    = junction_count_r + 1'b1;
  assign start_target = COUNT_BITS'(item.target_blocks);

  always_comb begin
    phase_nxt          = phase_r;
    junction_count_nxt = junction_count_r;
    target_count_nxt   = target_count_r;
    base_speed_nxt     = base_speed_r;
    sensor_finish_nxt  = sensor_finish_r;
    on_junction_nxt    = on_junction_r;
    since_junction_nxt = since_junction_r;
    phase_timer_nxt    = phase_timer_r;
    last_cmd_nxt       = last_cmd_r;
    last_speed_nxt     = last_speed_r;
    finish_sensor      = sensor_finish_r;
    do_finish          = 1'b0;
    do_end             = 1'b0;
    end_abort          = 1'b0;
    do_drive           = 1'b0;
    drv_cmd            = CMD_STOP;
    drv_speed          = '0;

    if (item.op == OP_START) begin
      target_count_nxt   = start_target;
      base_speed_nxt     = item.start_speed;
      sensor_finish_nxt  = item.center_by_sensor;
      finish_sensor      = item.center_by_sensor;
      junction_count_nxt = '0;
      on_junction_nxt    = 1'b1;
      since_junction_nxt = SINCE_MAX;
      phase_timer_nxt    = '0;
      last_cmd_nxt       = CMD_STOP;
      last_speed_nxt     = '0;
      phase_nxt          = PH_FOLLOW;
      do_finish          = (start_target == '0);
    end else if (phase_r == PH_IDLE) begin
      do_drive = 1'b0;
    end else if (phase_r == PH_CREEP || phase_r == PH_NUDGE) begin
      phase_timer_nxt = timer_inc;
      if (phase_r == PH_NUDGE) begin
        if (timer_ext >= CMP_W'(cfg.nudge_len)) begin
          do_end = 1'b1;
        end else begin
          do_drive = 1'b1;
        end
      end else if (timer_ext >= CMP_W'(cfg.creep_limit) || pat == PAT_M) begin
        do_end = 1'b1;
      end else if (item.stop_request) begin
        do_end    = 1'b1;
        end_abort = 1'b1;
      end else begin
        do_drive = 1'b1;
      end
      drv_cmd   = CMD_ADV;
      drv_speed = cfg.speed_floor;
    end else begin
      since_junction_nxt = since_inc;
      if (pat == PAT_ALL) begin
        if (!on_junction_r && (since_inc == SINCE_MAX || since_inc > cfg.debounce_ms)) begin
          junction_count_nxt = count_inc;
          since_junction_nxt = '0;
          on_junction_nxt    = 1'b1;
        end
        if (!on_junction_r && (since_inc == SINCE_MAX || since_inc > cfg.debounce_ms)
            && count_inc == target_count_r) begin
          do_finish = 1'b1;
          do_drive  = 1'b1;
          drv_cmd   = CMD_ADV;
          drv_speed = cfg.speed_floor;
        end else if (item.stop_request) begin
          do_end    = 1'b1;
          end_abort = 1'b1;
        end else begin
          do_drive  = 1'b1;
          drv_cmd   = CMD_ADV;
          drv_speed = cur_speed;
        end
      end else if (item.stop_request) begin
        do_end    = 1'b1;
        end_abort = 1'b1;
      end else begin
        do_drive = 1'b1;
        case (pat) inside
          PAT_NONE, PAT_M: begin
            on_junction_nxt = 1'b0;
            drv_cmd         = CMD_ADV;
            drv_speed       = cur_speed;
          end
          PAT_R, PAT_MR: begin
            on_junction_nxt = 1'b0;
            drv_cmd         = CMD_RIGHT;
            drv_speed       = boosted;
          end
          PAT_L, PAT_LM: begin
            on_junction_nxt = 1'b0;
            drv_cmd         = CMD_LEFT;
            drv_speed       = boosted;
          end
          default: begin
            drv_cmd   = last_cmd_r;
            drv_speed = last_speed_r;
          end
        endcase
      end
    end

    if (do_finish) begin
      phase_timer_nxt = '0;
      if (finish_sensor) begin
        phase_nxt = PH_CREEP;
      end else if (cfg.nudge_len != '0) begin
        phase_nxt = PH_NUDGE;
      end else begin
        do_end   = 1'b1;
        do_drive = 1'b0;
      end
    end

    res_cmd   = CMD_STOP;
    res_speed = '0;
    if (do_end) begin
      phase_nxt      = PH_IDLE;
      last_cmd_nxt   = CMD_STOP;
      last_speed_nxt = '0;
    end else if (do_drive) begin
      last_cmd_nxt   = drv_cmd;
      last_speed_nxt = drv_speed;
      res_cmd        = drv_cmd;
      res_speed      = (drv_cmd == CMD_STOP) ? 8'd0 : drv_speed;
    end
  end

  assign result.motor_cmd         = res_cmd;
  assign result.motor_speed       = res_speed;
  assign result.junctions_crossed = 4'(junction_count_nxt);
  assign result.busy_res          = (phase_nxt != PH_IDLE);
  assign result.finished          = do_end;
  assign result.aborted           = do_end & end_abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      junction_count_r <= '0;
      target_count_r   <= '0;
      base_speed_r     <= '0;
      sensor_finish_r  <= 1'b0;
      on_junction_r    <= 1'b1;
      since_junction_r <= SINCE_MAX;
      phase_timer_r    <= '0;
      last_cmd_r       <= CMD_STOP;
      last_speed_r     <= '0;
    end else if (fire) begin
      phase_r          <= phase_nxt;
      junction_count_r <= junction_count_nxt;
      target_count_r   <= target_count_nxt;
      base_speed_r     <= base_speed_nxt;
      sensor_finish_r  <= sensor_finish_nxt;
      on_junction_r    <= on_junction_nxt;
      since_junction_r <= since_junction_nxt;
      phase_timer_r    <= phase_timer_nxt;
      last_cmd_r       <= last_cmd_nxt;
      last_speed_r     <= last_speed_nxt;
    end
  end

endmodule

FILE: src/line_follow_junction_counter.sv
// ----------------------------------------------------------------------------
// line_follow_junction_counter
// Line-follow sequencer: one start or sensor-tick beat in, one motor
// command beat out.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat, which moves from the
// input register to the output register when the output register is free.
// The block takes a new beat in every cycle while the consumer does not stall:
// the beat sits in an input register, the move state and the motor decision
// are updated from that register, and the result lands in an output register
// that holds it while the consumer stalls. The state update loop through
// lfjc_core, one 4x8 multiply for the speed ramp plus a compare, sets the clock.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle, as the block does not enforce this.
module line_follow_junction_counter #(
  parameter int COUNT_BITS = 4,
  parameter int TIMER_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lfjc_in_if.sink                         in_ch,
  lfjc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lfjc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfjc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfjc_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      s1_fire;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;

  assign s1_fire       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || s1_fire;
  assign s1_valid_nxt  = in_ch.valid || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ch.ready);

  lfjc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfjc_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // A beat held in the input register is never dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r)
    else $error("input beat lost");

  // A finished move reports stop and no longer busy.
  a_fin_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.finished |->
      out_item_r.motor_cmd == CMD_STOP && !out_item_r.busy_res)
    else $error("finish beat not stopped");

  // Only a finished move can be aborted.
  a_abort_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.aborted |-> out_item_r.finished)
    else $error("abort without finish");

  // A stop command carries zero speed.
  a_stop_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.motor_cmd == CMD_STOP |-> out_item_r.motor_speed == 8'd0)
    else $error("speed on stop command");

endmodule
